>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define PSC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");
// checked on every edge, reset included
`define PSC_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("assertion failed");
`else
`define PSC_ASSERT(lbl, prop)
`define PSC_ASSERT_RST(lbl, prop)
`endif
`endif

>>> src/psc_pkg.sv
// ---------------------------------------------------------------------------
// psc_pkg
// Constants and types shared by the point set covariance block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package psc_pkg;
	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 24;
	localparam int ACC_W = 64;   // product sums wrap at this width
	localparam int VAR_W = 47;
	localparam int COV_W = 48;
	localparam int PU_W  = 11;
	localparam int PU_MAX = 2047;
	localparam logic signed [ACC_W-1:0] VAR_MAX = 64'sd140737488355327;
	localparam logic signed [ACC_W-1:0] COV_MIN = -64'sd140737488355328;

	// back end status seen by the front end
	typedef struct packed {
		logic store_free;   // last store read issued, store may be refilled
		logic pass_active;  // second pass is reading the store
	} back_stat_t;
endpackage

>>> src/psc_fifo.sv
// ---------------------------------------------------------------------------
// psc_fifo
// Short job queue between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module psc_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

>>> src/psc_front.sv
// ---------------------------------------------------------------------------
// psc_front
// Takes points, fills the point store, keeps sums and count, queues jobs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psc_front #(
	parameter int MAX_POINTS = psc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = psc_pkg::COORD_BITS_DEF,
	localparam int AW    = $clog2(MAX_POINTS),
	localparam int CNT_W = $clog2(MAX_POINTS + 1),
	localparam int SUM_W = COORD_BITS + CNT_W + 1,
	localparam int JOB_W = 3 * SUM_W + CNT_W + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [3*COORD_BITS-1:0] in_coords,
	input  logic                    in_last,
	output logic                    job_push,
	output logic [JOB_W-1:0]        job_data,
	input  logic                    job_full,
	input  psc_pkg::back_stat_t     stat,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	output logic [3*COORD_BITS-1:0] rd_data
);
	logic [3*COORD_BITS-1:0] store_q [MAX_POINTS];
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [SUM_W-1:0] sum_nx [3];
	logic [CNT_W-1:0]        count_q, count_nx;
	logic                    drop_q, drop_nx;
	logic                    busy_q;
	logic                    acc, room;

	assign in_ready = !busy_q && !job_full;
	assign acc      = in_valid && in_ready;
	assign room     = (count_q < CNT_W'(MAX_POINTS));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_nx[k] = room ? sum_q[k] + SUM_W'($signed(in_coords[k*COORD_BITS +: COORD_BITS]))
			                 : sum_q[k];
		end
		count_nx = room ? count_q + CNT_W'(1) : count_q;
		drop_nx  = drop_q || !room;
	end

	assign job_push = acc && in_last;
	assign job_data = {drop_nx, count_nx, sum_nx[2], sum_nx[1], sum_nx[0]};

	always_ff @(posedge clk) begin
		if (acc && room) store_q[count_q[AW-1:0]] <= in_coords;
		if (rd_en) rd_data <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) sum_q[k] <= '0;
			count_q <= '0;
			drop_q  <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			if (acc) begin
				if (in_last) begin
					for (int k = 0; k < 3; k++) sum_q[k] <= '0;
					count_q <= '0;
					drop_q  <= 1'b0;
					busy_q  <= 1'b1;
				end else begin
					sum_q   <= sum_nx;
					count_q <= count_nx;
					drop_q  <= drop_nx;
				end
			end else if (stat.store_free) begin
				busy_q <= 1'b0;
			end
		end
	end

	// store reads of the second pass only happen while the store is locked
	`PSC_ASSERT(a_pass_locks_store, (stat.pass_active && rd_en) |-> busy_q)
	`PSC_ASSERT(a_last_clears, (acc && in_last) |=> (busy_q && count_q == '0))
	`PSC_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_POINTS))
endmodule

>>> src/psc_div.sv
// ---------------------------------------------------------------------------
// psc_div
// Signed by unsigned divider, truncating, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module psc_div #(
	parameter int DVS_W = 11
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [psc_pkg::ACC_W-1:0] dividend,
	input  logic [DVS_W-1:0]               divisor,
	output logic                           busy,
	output logic                           done,
	output logic signed [psc_pkg::ACC_W-1:0] quotient
);
	localparam int W  = psc_pkg::ACC_W;
	localparam int BW = $clog2(W);

	logic [W-1:0]     mag_q, quo_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DVS_W:0]   rem_sh;
	logic             ge, neg_q, busy_q, done_q;
	logic [BW-1:0]    bit_q;

	assign rem_sh   = {rem_q, mag_q[W-1]};
	assign ge       = (rem_sh >= {1'b0, dvs_q});
	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
			neg_q <= dividend[W-1];
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[W-2:0], 1'b0};
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + BW'(1);
				if (bit_q == BW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

>>> src/psc_back.sv
// ---------------------------------------------------------------------------
// psc_back
// Mean, second pass over the store, product sums, division and result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psc_back #(
	parameter int MAX_POINTS = psc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = psc_pkg::COORD_BITS_DEF,
	parameter int OUT_W = 368,
	localparam int AW    = $clog2(MAX_POINTS),
	localparam int CNT_W = $clog2(MAX_POINTS + 1),
	localparam int SUM_W = COORD_BITS + CNT_W + 1,
	localparam int JOB_W = 3 * SUM_W + CNT_W + 1,
	localparam int D_W   = COORD_BITS + 1,
	localparam int RAW_W = 3 * COORD_BITS + 3 * psc_pkg::VAR_W + 3 * psc_pkg::COV_W
	                       + psc_pkg::PU_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_empty,
	input  logic [JOB_W-1:0]        job_data,
	output logic                    job_pop,
	output psc_pkg::back_stat_t     stat,
	output logic                    rd_en,
	output logic [AW-1:0]           rd_addr,
	input  logic [3*COORD_BITS-1:0] rd_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [OUT_W-1:0]        out_data,
	output logic                    out_flag
);
	localparam int W = psc_pkg::ACC_W;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MEAN = 3'd1;
	localparam logic [2:0] ST_PASS = 3'd2;
	localparam logic [2:0] ST_PDIV = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]               state_q;
	logic signed [SUM_W-1:0]  sum_q [3];
	logic [CNT_W-1:0]         cnt_q, iss_q;
	logic                     drop_q;
	logic [2:0]               k_q;
	logic                     div_run_q;
	logic signed [COORD_BITS-1:0] mean_q [3];
	logic signed [W-1:0]      acc_q [6];
	logic signed [W-1:0]      res_q [6];
	logic                     v_s1, v_s2, v_s3;
	logic signed [D_W-1:0]    d_s2 [3];
	logic signed [2*D_W-1:0]  p_s3 [6];
	logic                     div_start, div_busy, div_done;
	logic signed [W-1:0]      div_a, div_q;
	logic                     out_valid_q, out_flag_q;
	logic [OUT_W-1:0]         out_data_q;
	logic [RAW_W-1:0]         raw;
	logic [psc_pkg::VAR_W-1:0] vr [3];
	logic [psc_pkg::COV_W-1:0] cov_c [3];
	logic [psc_pkg::PU_W-1:0]  pu;

	assign div_start = (state_q == ST_MEAN || state_q == ST_PDIV) && !div_run_q;
	assign div_a     = (state_q == ST_MEAN) ? W'(sum_q[k_q[1:0]]) : acc_q[k_q];

	psc_div #(.DVS_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (cnt_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign job_pop          = (state_q == ST_IDLE) && !job_empty;
	assign rd_en            = (state_q == ST_PASS) && (iss_q < cnt_q);
	assign rd_addr          = iss_q[AW-1:0];
	assign stat.store_free  = rd_en && (iss_q == cnt_q - CNT_W'(1));
	assign stat.pass_active = (state_q == ST_PASS);

	// clamp the quotients into the result fields
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic signed [W-1:0] v, c;
			v = res_q[(j == 0) ? 0 : (j == 1) ? 3 : 5];
			c = res_q[(j == 0) ? 1 : (j == 1) ? 2 : 4];
			if (v[W-1])              vr[j] = '0;
			else if (v > psc_pkg::VAR_MAX) vr[j] = psc_pkg::VAR_W'(psc_pkg::VAR_MAX);
			else                     vr[j] = v[psc_pkg::VAR_W-1:0];
			if (c > psc_pkg::VAR_MAX)      cov_c[j] = psc_pkg::COV_W'(psc_pkg::VAR_MAX);
			else if (c < psc_pkg::COV_MIN) cov_c[j] = psc_pkg::COV_W'(psc_pkg::COV_MIN);
			else                     cov_c[j] = c[psc_pkg::COV_W-1:0];
		end
		pu  = (32'(cnt_q) > 32'(psc_pkg::PU_MAX)) ? psc_pkg::PU_W'(psc_pkg::PU_MAX)
		                                         : psc_pkg::PU_W'(cnt_q);
		raw = {pu, vr[2], cov_c[2], vr[1], cov_c[1], cov_c[0], vr[0],
		       mean_q[2], mean_q[1], mean_q[0]};
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_flag  = out_flag_q;

	// pass datapath: deviations, then six products
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			d_s2[j] <= D_W'($signed(rd_data[j*COORD_BITS +: COORD_BITS])) - D_W'(mean_q[j]);
		end
		p_s3[0] <= d_s2[0] * d_s2[0];
		p_s3[1] <= d_s2[0] * d_s2[1];
		p_s3[2] <= d_s2[0] * d_s2[2];
		p_s3[3] <= d_s2[1] * d_s2[1];
		p_s3[4] <= d_s2[1] * d_s2[2];
		p_s3[5] <= d_s2[2] * d_s2[2];
		if (state_q == ST_OUT && !out_valid_q) out_data_q <= OUT_W'(raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			div_run_q   <= 1'b0;
			iss_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			out_flag_q  <= 1'b0;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				sum_q[j]  <= '0;
				mean_q[j] <= '0;
			end
			for (int j = 0; j < 6; j++) begin
				acc_q[j] <= '0;
				res_q[j] <= '0;
			end
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (div_start) div_run_q <= 1'b1;
			if (v_s3) begin
				for (int j = 0; j < 6; j++) acc_q[j] <= acc_q[j] + W'(p_s3[j]);
			end
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						{drop_q, cnt_q, sum_q[2], sum_q[1], sum_q[0]} <= job_data;
						for (int j = 0; j < 6; j++) acc_q[j] <= '0;
						k_q     <= '0;
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (div_done) begin
						mean_q[k_q[1:0]] <= div_q[COORD_BITS-1:0];
						div_run_q <= 1'b0;
						if (k_q == 3'd2) begin
							k_q     <= '0;
							iss_q   <= '0;
							state_q <= ST_PASS;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				ST_PASS: begin
					if (rd_en) iss_q <= iss_q + CNT_W'(1);
					else if (!v_s1 && !v_s2 && !v_s3) state_q <= ST_PDIV;
				end
				ST_PDIV: begin
					if (div_done) begin
						res_q[k_q] <= div_q;
						div_run_q  <= 1'b0;
						if (k_q == 3'd5) state_q <= ST_OUT;
						else             k_q <= k_q + 3'd1;
					end
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_flag_q  <= drop_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PSC_ASSERT(a_div_idle_on_start, div_start |-> !div_busy)
	`PSC_ASSERT(a_free_in_pass, stat.store_free |-> (state_q == ST_PASS))
	`PSC_ASSERT(a_acc_in_pass, v_s3 |-> (state_q == ST_PASS))
endmodule

>>> src/point_set_covariance_top.sv
// ---------------------------------------------------------------------------
// point_set_covariance_top
// Mean and 3x3 covariance of the points of one cell, two passes.
// ---------------------------------------------------------------------------
// Points: one item per cycle while the cell is loading and the job queue is not full (store write port).
// Per cell after the last point: 3 divisions for the mean, a pass over the
// store read port for the product sums, then 6 more divisions.
// Input is held off from the last point until the second pass has issued its
// final store read. Reset (arst_n low, async) clears sums, count, flags, the
// job queue and the output valid; the point store and output data are not cleared.
`timescale 1ns / 1ps
module point_set_covariance_top #(
	parameter int MAX_POINTS = psc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = psc_pkg::COORD_BITS_DEF,
	localparam int IN_W  = ((3 * COORD_BITS + 7) / 8) * 8,
	localparam int RAW_W = 3 * COORD_BITS + 3 * psc_pkg::VAR_W + 3 * psc_pkg::COV_W
	                       + psc_pkg::PU_W,
	localparam int OUT_W = ((RAW_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// input items: one point each
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z, zero pad
	input  logic             s_tlast,   // last_point
	// result items: one per cell
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // mean_x, mean_y, mean_z, var_xx, cov_xy,
	                                    // cov_xz, var_yy, cov_yz, var_zz, points_used
	output logic             m_tuser    // overflow
);
	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SUM_W = COORD_BITS + CNT_W + 1;
	localparam int JOB_W = 3 * SUM_W + CNT_W + 1;

	logic                    job_push, job_full, job_pop, job_empty;
	logic [JOB_W-1:0]        job_wdata, job_rdata;
	psc_pkg::back_stat_t     stat;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [3*COORD_BITS-1:0] rd_data;

	// front end: store writes, running sums, count, drop flag
	psc_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_coords (s_tdata[3*COORD_BITS-1:0]),
		.in_last   (s_tlast),
		.job_push  (job_push),
		.job_data  (job_wdata),
		.job_full  (job_full),
		.stat      (stat),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// one job per cell: sums, count, drop flag
	psc_fifo #(.W(JOB_W)) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_wdata),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.empty  (job_empty)
	);

	// back end: mean, second pass, divisions, output register
	psc_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS), .OUT_W(OUT_W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_data  (job_rdata),
		.job_pop   (job_pop),
		.stat      (stat),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_flag  (m_tuser)
	);
endmodule
